>>> hdl/trre_pkg.sv
// Package with shared types, tables and helper functions of the row record builder.
`timescale 1ns / 1ps
package trre_pkg;

  localparam int         NUM_CHANNELS  = 4;
  localparam logic [6:0] REST_NOTE_MAX = 7'd96;
  localparam logic [7:0] EFFECT_E      = 8'd14;
  localparam logic [3:0] PARAM_DETUNE  = 4'h5;
  localparam logic [3:0] PARAM_CUT     = 4'hC;
  localparam logic [3:0] DETUNE_RESET  = 4'd8;
  localparam logic [7:0] CUT_RESET     = 8'hFF;
  localparam logic [7:0] MODE_BOTH     = 8'h80;
  localparam logic [7:0] MODE_NOISE    = 8'h01;
  localparam logic [7:0] MODE_SLIDE    = 8'h04;
  localparam logic [7:0] MODE_NONE     = 8'h00;
  localparam logic [4:0] CELL_MASK     = 5'h1E;

  // Row snapshot passed from the parser to the record stage.
  typedef struct packed {
    logic [3:0][6:0] note;
    logic [3:0][7:0] instr;
    logic [3:0][3:0] detune;
    logic [7:0]      cut;
  } row_snap_t;

  function automatic logic [15:0] note_lookup(input logic [6:0] n);
    logic [15:0] t;
    case (n)
      7'd1: t = 16'h00C0; 7'd2: t = 16'h00CB; 7'd3: t = 16'h00D8; 7'd4: t = 16'h00E4;
      7'd5: t = 16'h00F2; 7'd6: t = 16'h0100; 7'd7: t = 16'h0110; 7'd8: t = 16'h0120;
      7'd9: t = 16'h0131; 7'd10: t = 16'h0143; 7'd11: t = 16'h0156; 7'd12: t = 16'h016A;
      7'd13: t = 16'h0180; 7'd14: t = 16'h0197; 7'd15: t = 16'h01AF; 7'd16: t = 16'h01C9;
      7'd17: t = 16'h01E4; 7'd18: t = 16'h0201; 7'd19: t = 16'h021F; 7'd20: t = 16'h023F;
      7'd21: t = 16'h0262; 7'd22: t = 16'h0286; 7'd23: t = 16'h02AC; 7'd24: t = 16'h02D5;
      7'd25: t = 16'h0300; 7'd26: t = 16'h032E; 7'd27: t = 16'h035E; 7'd28: t = 16'h0391;
      7'd29: t = 16'h03C8; 7'd30: t = 16'h0401; 7'd31: t = 16'h043E; 7'd32: t = 16'h047F;
      7'd33: t = 16'h04C3; 7'd34: t = 16'h050C; 7'd35: t = 16'h0558; 7'd36: t = 16'h05AA;
      7'd37: t = 16'h0600; 7'd38: t = 16'h065B; 7'd39: t = 16'h06BC; 7'd40: t = 16'h0723;
      7'd41: t = 16'h078F; 7'd42: t = 16'h0802; 7'd43: t = 16'h087C; 7'd44: t = 16'h08FD;
      7'd45: t = 16'h0986; 7'd46: t = 16'h0A17; 7'd47: t = 16'h0AB1; 7'd48: t = 16'h0B54;
      7'd49: t = 16'h0C00; 7'd50: t = 16'h0CB7; 7'd51: t = 16'h0D78; 7'd52: t = 16'h0E45;
      7'd53: t = 16'h0F1E; 7'd54: t = 16'h1005; 7'd55: t = 16'h10F8; 7'd56: t = 16'h11FB;
      7'd57: t = 16'h130D; 7'd58: t = 16'h142E; 7'd59: t = 16'h1562; 7'd60: t = 16'h16A7;
      7'd61: t = 16'h1800; 7'd62: t = 16'h196D; 7'd63: t = 16'h1AF0; 7'd64: t = 16'h1C8A;
      7'd65: t = 16'h1E3D; 7'd66: t = 16'h2009; 7'd67: t = 16'h21F1; 7'd68: t = 16'h23F6;
      7'd69: t = 16'h2619; 7'd70: t = 16'h285D; 7'd71: t = 16'h2AC3; 7'd72: t = 16'h2D4E;
      7'd73: t = 16'h3000; 7'd74: t = 16'h32DB; 7'd75: t = 16'h35E1; 7'd76: t = 16'h3915;
      7'd77: t = 16'h3C7A; 7'd78: t = 16'h4013; 7'd79: t = 16'h43E2; 7'd80: t = 16'h47EB;
      7'd81: t = 16'h4C32; 7'd82: t = 16'h50BA; 7'd83: t = 16'h5587; 7'd84: t = 16'h5A9D;
      7'd85: t = 16'h6000; 7'd86: t = 16'h65B5; 7'd87: t = 16'h6BC2; 7'd88: t = 16'h722A;
      7'd89: t = 16'h78F4; 7'd90: t = 16'h8025; 7'd91: t = 16'h87C4; 7'd92: t = 16'h8FD6;
      7'd93: t = 16'h9864; 7'd94: t = 16'hA174; 7'd95: t = 16'hAB0E; 7'd96: t = 16'hB539;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

  // Noise pattern for a stored note, repeating every twelve notes.
  function automatic logic [15:0] noise_lookup(input logic [6:0] n);
    logic [2:0]  s;
    logic [1:0]  r;
    logic [3:0]  pos;
    logic [15:0] t;
    // The note mod 12 is 4 * ((n >> 2) mod 3) + (n mod 4); powers of two mod 3 alternate 1, 2.
    s = {2'd0, n[2]} + {1'd0, n[3], 1'b0} + {2'd0, n[4]} + {1'd0, n[5], 1'b0} + {2'd0, n[6]};
    case (s)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    pos = {r, n[1:0]};
    case (pos)
      4'd0: t = 16'hCD44; 4'd1: t = 16'h0CBA; 4'd2: t = 16'h0744; 4'd3: t = 16'h099A;
      4'd4: t = 16'h188B; 4'd5: t = 16'h18BB; 4'd6: t = 16'hDD55; 4'd7: t = 16'hED66;
      4'd8: t = 16'hC400; 4'd9: t = 16'hB400; 4'd10: t = 16'h0143; 4'd11: t = 16'hC111;
      default: t = 16'h0000;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] duty_plain(input logic [7:0] i);
    logic [7:0] d;
    case (i)
      8'd1: d = 8'h80; 8'd2: d = 8'h40; 8'd3: d = 8'h20; 8'd4: d = 8'h10;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

>>> hdl/tracker_row_to_engine_record.sv
// Top level: byte stream parser and row record builder with an output register.
`timescale 1ns / 1ps
// Channel | Ports                                  | Direction
// in      | in_valid, in_stall, in_stream_byte, ... | byte beats in
// out     | out_valid, out_stall, out_* fields      | row record beats out
// cfg     | cfg_we, cfg_data                       | tempo register write
// A byte beat is taken in each cycle with in_valid high and no stall; a row
// record appears in the cycle after the byte that completes the fourth channel.
// Input is stalled only while a record waits in the output register and is not
// taken. Synchronous reset restores parser start state and sets tempo to 6.
module tracker_row_to_engine_record (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_stream_byte,
  input  logic        in_pattern_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_row_mode_length,
  output logic [15:0] out_duty_pair_12,
  output logic [15:0] out_duty_pair_34,
  output logic [15:0] out_pitch_one,
  output logic [15:0] out_pitch_two,
  output logic [15:0] out_pitch_three,
  output logic [15:0] out_pitch_four,
  output logic        out_bad_instrument,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import trre_pkg::*;

  logic [7:0]       tempo_r;
  logic             step, row_done;
  row_snap_t        snap;
  logic [15:0]      ml, d12, d34;
  logic [3:0][15:0] pitch;
  logic             bad;
  logic             ov_r;

  assign in_stall = ov_r && out_stall;
  assign step     = in_valid && !in_stall;

  // Tempo register.
  always_ff @(posedge clk) begin
    if (!rst_n) tempo_r <= 8'd6;
    else if (cfg_we) tempo_r <= cfg_data;
  end

  trre_parser u_parser (
    .clk, .rst_n, .step,
    .stream_byte(in_stream_byte), .pattern_start(in_pattern_start),
    .tempo(tempo_r), .row_done, .snap
  );

  trre_record u_record (
    .snap, .mode_length(ml), .duty_12(d12), .duty_34(d34), .pitch, .bad
  );

  // Output register holds one record beat.
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (step && row_done) ov_r <= 1'b1;
    else if (!out_stall) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step && row_done) begin
      out_row_mode_length <= ml;
      out_duty_pair_12    <= d12;
      out_duty_pair_34    <= d34;
      out_pitch_one       <= pitch[0];
      out_pitch_two       <= pitch[1];
      out_pitch_three     <= pitch[2];
      out_pitch_four      <= pitch[3];
      out_bad_instrument  <= bad;
    end
  end

  assign out_valid = ov_r;

endmodule

>>> hdl/trre_parser.sv
// Byte parser holding per-channel note, instrument, detune and row cut state.
`timescale 1ns / 1ps
module trre_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          stream_byte,
  input  logic                pattern_start,
  input  logic [7:0]          tempo,
  output logic                row_done,
  output trre_pkg::row_snap_t snap
);
  import trre_pkg::*;

  logic [1:0]      chan_r, chan_nxt;
  logic            phase_r, phase_nxt;
  logic [4:0]      mask_r, mask_nxt;
  logic [7:0]      eff_r, eff_nxt;
  logic [3:0][6:0] note_r, note_nxt;
  logic [3:0][7:0] instr_r, instr_nxt;
  logic [3:0][3:0] det_r, det_nxt;
  logic [7:0]      cut_r, cut_nxt;

  // Next-state logic for one byte.
  always_comb begin
    logic [6:0] n;
    logic [4:0] m;
    logic       done;
    chan_nxt  = chan_r;
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    eff_nxt   = eff_r;
    note_nxt  = note_r;
    instr_nxt = instr_r;
    det_nxt   = det_r;
    cut_nxt   = cut_r;
    done      = 1'b0;
    n         = (stream_byte > 8'(REST_NOTE_MAX)) ? 7'd0 : stream_byte[6:0];
    m         = mask_r;
    if (pattern_start) begin
      note_nxt  = '0;
      instr_nxt = '0;
      chan_nxt  = 2'd0;
      phase_nxt = 1'b0;
      mask_nxt  = 5'd0;
      eff_nxt   = 8'd0;
      det_nxt   = {4{DETUNE_RESET}};
      cut_nxt   = CUT_RESET;
      m         = 5'd0;
    end
    if (!phase_nxt) begin
      eff_nxt = 8'd0;
      if (stream_byte[7]) begin
        mask_nxt = stream_byte[4:0];
      end else begin
        note_nxt[chan_nxt] = n;
        if (n == 7'd0) instr_nxt[chan_nxt] = 8'd0;
        mask_nxt = CELL_MASK;
      end
      if (mask_nxt == 5'd0) done = 1'b1;
      else phase_nxt = 1'b1;
    end else begin
      // Lowest pending field takes this byte.
      if (m[0]) begin
        note_nxt[chan_nxt] = n;
        if (n == 7'd0) instr_nxt[chan_nxt] = 8'd0;
        mask_nxt = {m[4:1], 1'b0};
      end else if (m[1]) begin
        if (note_r[chan_nxt] != 7'd0) instr_nxt[chan_nxt] = stream_byte;
        mask_nxt = {m[4:2], 2'b0};
      end else if (m[2]) begin
        mask_nxt = {m[4:3], 3'b0};
      end else if (m[3]) begin
        eff_nxt  = stream_byte;
        mask_nxt = {m[4], 4'b0};
      end else begin
        if (eff_r == EFFECT_E) begin
          if (stream_byte[7:4] == PARAM_DETUNE) det_nxt[chan_nxt] = stream_byte[3:0];
          if (stream_byte[7:4] == PARAM_CUT && tempo > {4'd0, stream_byte[3:0]})
            cut_nxt = tempo - {4'd0, stream_byte[3:0]};
        end
        mask_nxt = 5'd0;
      end
      if (mask_nxt == 5'd0) begin
        phase_nxt = 1'b0;
        done      = 1'b1;
      end
    end
    row_done = done && (chan_nxt == 2'(NUM_CHANNELS - 1));
    snap.note   = note_nxt;
    snap.instr  = instr_nxt;
    snap.detune = det_nxt;
    snap.cut    = cut_nxt;
    if (done) chan_nxt = chan_nxt + 2'd1;
    if (row_done) begin
      det_nxt = {4{DETUNE_RESET}};
      cut_nxt = CUT_RESET;
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r  <= 2'd0;
      phase_r <= 1'b0;
      mask_r  <= 5'd0;
      eff_r   <= 8'd0;
      note_r  <= '0;
      instr_r <= '0;
      det_r   <= {4{DETUNE_RESET}};
      cut_r   <= CUT_RESET;
    end else if (step) begin
      chan_r  <= chan_nxt;
      phase_r <= phase_nxt;
      mask_r  <= mask_nxt;
      eff_r   <= eff_nxt;
      note_r  <= note_nxt;
      instr_r <= instr_nxt;
      det_r   <= det_nxt;
      cut_r   <= cut_nxt;
    end
  end

endmodule

>>> hdl/trre_record.sv
// Record builder: turns a row snapshot into mode, duty, detuned pitch and bad fields.
`timescale 1ns / 1ps
module trre_record (
  input  trre_pkg::row_snap_t snap,
  output logic [15:0]         mode_length,
  output logic [15:0]         duty_12,
  output logic [15:0]         duty_34,
  output logic [3:0][15:0]    pitch,
  output logic                bad
);
  import trre_pkg::*;

  logic [7:0]       i1, i2, i3, i4, d3, d4, mode;
  logic [3:0][15:0] base;

  assign i1 = snap.instr[0];
  assign i2 = snap.instr[1];
  assign i3 = snap.instr[2];
  assign i4 = snap.instr[3];

  // Duty and mode selection from the instruments.
  always_comb begin
    case (i3)
      8'd1, 8'd9:  d3 = 8'h80;
      8'd2, 8'd10: d3 = 8'h40;
      8'd3:        d3 = 8'h20;
      8'd4:        d3 = 8'h10;
      default:     d3 = 8'h00;
    endcase
    if (i4 >= 8'd1 && i4 <= 8'd8) d4 = duty_plain({6'd0, 2'(i4 - 8'd1)} + 8'd1);
    else d4 = 8'h00;
    if (i4 > 8'd4 && i3 > 8'd8) mode = MODE_BOTH;
    else if (i4 > 8'd4) mode = MODE_NOISE;
    else if (i3 > 8'd8) mode = MODE_SLIDE;
    else mode = MODE_NONE;
  end

  assign bad = (i1 > 8'd4) || (i2 > 8'd4) || (i4 > 8'd8) || (i3 > 8'd4 && i3 < 8'd9);
  assign mode_length = {snap.cut, mode};
  assign duty_12 = {duty_plain(i1), duty_plain(i2)};
  assign duty_34 = {d3, d4};

  // Detune: p - trunc(p * (8 - d) / 100); the offset is signed.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [20:0] prod;
      logic [20:0] q;
      logic        neg;
      logic [3:0]  k;
      if (c == 3 && i4 >= 8'd5) base[c] = noise_lookup(snap.note[c]);
      else base[c] = note_lookup(snap.note[c]);
      neg = snap.detune[c] > 4'd8;
      k   = neg ? (snap.detune[c] - 4'd8) : (4'd8 - snap.detune[c]);
      prod = 21'(base[c]) * 21'(k);
      // Divide by 100 through reciprocal 671089 / 2^26, exact for values below 2^20.
      q = 21'((40'(prod) * 40'd671089) >> 26);
      if (neg) pitch[c] = base[c] + q[15:0];
      else pitch[c] = base[c] - q[15:0];
    end
  end

endmodule
